@@ sv/mbc_pkg.sv @@
package mbc_pkg;

    localparam int MAX_SIDE    = 127;
    localparam int STACK_DEPTH = 4096;

    localparam int MAP_SIDE = MAX_SIDE + 1;
    localparam int COORD_W  = $clog2(MAP_SIDE);
    localparam int STACK_AW = $clog2(STACK_DEPTH);
    localparam int COUNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int ENTRY_W  = 2 * COORD_W;

    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_STEP  = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic [1:0] KIND_OPEN = 2'd0;
    localparam logic [1:0] KIND_BACK = 2'd1;
    localparam logic [1:0] KIND_DONE = 2'd2;
    localparam logic [1:0] KIND_READ = 2'd3;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // candidate directions, bit order of the candidate mask
    localparam logic [1:0] DIR_N = 2'd0;
    localparam logic [1:0] DIR_E = 2'd1;
    localparam logic [1:0] DIR_S = 2'd2;
    localparam logic [1:0] DIR_W = 2'd3;

    typedef logic [MAP_SIDE-1:0] t_row;

    typedef struct packed {
        logic               rd;
        logic               wr;
        logic               clr;
        logic [COORD_W-1:0] row;
        t_row               wdata;
    } t_map_req;

    typedef struct packed {
        logic                rd;
        logic                wr;
        logic [STACK_AW-1:0] addr;
        logic [ENTRY_W-1:0]  wdata;
    } t_stk_req;

    function automatic logic [COORD_W-1:0] eff_size(input logic [COORD_W-1:0] r);
        logic [COORD_W-1:0] s;
        s = r;
        if (r < COORD_W'(3)) s = COORD_W'(3);
        if (r > COORD_W'(MAX_SIDE)) s = COORD_W'(MAX_SIDE);
        return s;
    endfunction

    function automatic t_row onehot_row(input logic [COORD_W-1:0] idx);
        return t_row'(1) << idx;
    endfunction

    // rand mod 3 via base-4 digit sum (4 = 1 mod 3)
    function automatic logic [1:0] mod3(input logic [7:0] v);
        logic [3:0] s;
        logic [2:0] t;
        logic [1:0] m;
        s = 4'(v[1:0]) + 4'(v[3:2]) + 4'(v[5:4]) + 4'(v[7:6]);
        t = 3'(s[3:2]) + 3'(s[1:0]);
        if (t >= 3'd6)      m = 2'(t - 3'd6);
        else if (t >= 3'd3) m = 2'(t - 3'd3);
        else                m = t[1:0];
        return m;
    endfunction

    function automatic logic [1:0] mod_count(input logic [7:0] v, input logic [2:0] n);
        logic [1:0] m;
        case (n)
            3'd2:    m = {1'b0, v[0]};
            3'd3:    m = mod3(v);
            3'd4:    m = v[1:0];
            default: m = 2'd0;
        endcase
        return m;
    endfunction

    // direction of the pick-th set bit of the candidate mask
    function automatic logic [1:0] pick_dir(input logic [3:0] cand, input logic [1:0] pick);
        logic [2:0] seen;
        logic [1:0] d;
        seen = 3'd0;
        d    = DIR_N;
        for (int i = 0; i < 4; i++) begin
            if (cand[i]) begin
                if (seen == {1'b0, pick}) d = 2'(i);
                seen = seen + 3'd1;
            end
        end
        return d;
    endfunction

endpackage

@@ sv/mbc_map.sv @@
// Open map: one row of cells per word, single port, registered read.
// Per-row valid bits stand in for a clear; an invalid row reads as all walls.
module mbc_map (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mbc_pkg::t_map_req i_req,
    output mbc_pkg::t_row     o_rdata
);

    mbc_pkg::t_row                   r_mem [mbc_pkg::MAP_SIDE];
    logic [mbc_pkg::MAP_SIDE-1:0]    r_valid;
    mbc_pkg::t_row                   r_q;
    logic                            r_q_valid;

    always_ff @(posedge i_clk) begin
        if (i_req.wr) begin
            r_mem[i_req.row] <= i_req.wdata;
        end
        if (i_req.rd) begin
            r_q <= r_mem[i_req.row];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_q_valid <= 1'b0;
        end else begin
            if (i_req.clr) begin
                r_valid <= '0;
            end else if (i_req.wr) begin
                r_valid[i_req.row] <= 1'b1;
            end
            if (i_req.rd) begin
                r_q_valid <= r_valid[i_req.row];
            end
        end
    end

    assign o_rdata = r_q_valid ? r_q : '0;

endmodule

@@ sv/mbc_stack.sv @@
// Path stack storage: single port, registered read.
module mbc_stack (
    input  logic                              i_clk,
    input  mbc_pkg::t_stk_req                 i_req,
    output logic [mbc_pkg::ENTRY_W-1:0]       o_rdata
);

    logic [mbc_pkg::ENTRY_W-1:0] r_mem [mbc_pkg::STACK_DEPTH];
    logic [mbc_pkg::ENTRY_W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_req.wr) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end else if (i_req.rd) begin
            r_q <= r_mem[i_req.addr];
        end
    end

    assign o_rdata = r_q;

endmodule

@@ sv/maze_backtracker_carver_core.sv @@
// Each command runs as a sequence of states: start opens three cells (three results in a row);
//   step gives one result (done or backtrack) or two (carve); read gives one.
//   The single map port (one row access per cycle) sets how long each sequence runs.
// Throughput: one item at a time; busy is high until the last result is issued, so the next
//   item can be taken at the edge that takes the last result.
// Reset: synchronous active low; map row valid bits and stack count clear at once; no stalls.
module maze_backtracker_carver_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // command channel
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    i_command,
    input  logic [7:0]                    i_rand_value,
    input  logic [mbc_pkg::COORD_W-1:0]   i_cell_x,
    input  logic [mbc_pkg::COORD_W-1:0]   i_cell_y,
    // configuration
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [mbc_pkg::COORD_W-1:0]   i_cfg_data,
    // results
    output logic                          o_strobe,
    output logic [1:0]                    o_kind,
    output logic [mbc_pkg::COORD_W-1:0]   o_pos_x,
    output logic [mbc_pkg::COORD_W-1:0]   o_pos_y,
    output logic                          o_is_open,
    output logic                          o_last
);

    localparam int CW = mbc_pkg::COORD_W;
    localparam int NW = CW + 1;   // coordinate plus headroom for +2

    // sequencer, one-hot
    typedef enum logic [16:0] {
        S_IDLE  = 17'b00000000000000001,
        S_CLR   = 17'b00000000000000010,  // drop all rows, push first cell
        S_ENT   = 17'b00000000000000100,  // open entrance
        S_EXIT  = 17'b00000000000001000,  // open exit
        S_FIRST = 17'b00000000000010000,  // open first cell
        S_TOP   = 17'b00000000000100000,  // read stack top
        S_CUR   = 17'b00000000001000000,  // latch top, read own row
        S_RN    = 17'b00000000010000000,  // east/west bits, read north row
        S_RS    = 17'b00000000100000000,  // north bit, read south row
        S_PICK  = 17'b00000001000000000,  // build candidate mask
        S_SEL   = 17'b00000010000000000,  // choose or backtrack
        S_MRD   = 17'b00000100000000000,  // read wall row
        S_MWR   = 17'b00001000000000000,  // open wall cell, push
        S_NRD   = 17'b00010000000000000,  // read new cell row
        S_NWR   = 17'b00100000000000000,  // open new cell
        S_RD0   = 17'b01000000000000000,  // read request row
        S_RD1   = 17'b10000000000000000   // report read data
    } t_state;

    t_state                          r_state, n_state;
    logic [mbc_pkg::COUNT_W-1:0]     r_cnt, n_cnt;
    logic [7:0]                      r_rand, n_rand;
    logic [CW-1:0]                   r_cx, n_cx, r_cy, n_cy;
    logic                            r_ob_e, n_ob_e, r_ob_w, n_ob_w, r_ob_n, n_ob_n;
    logic [3:0]                      r_cand, n_cand;
    logic [CW-1:0]                   r_nx, n_nx, r_ny, n_ny, r_mx, n_mx, r_my, n_my;
    logic [CW-1:0]                   r_width, r_height;

    logic                            r_out_valid, n_out_valid;
    logic [1:0]                      r_out_kind, n_out_kind;
    logic [CW-1:0]                   r_out_x, n_out_x, r_out_y, n_out_y;
    logic                            r_out_open, n_out_open, r_out_last, n_out_last;

    mbc_pkg::t_map_req               map_req;
    mbc_pkg::t_row                   map_q;
    mbc_pkg::t_stk_req               stk_req;
    logic [mbc_pkg::ENTRY_W-1:0]     stk_q;

    logic [CW-1:0]                   w_eff, h_eff;
    logic [NW-1:0]                   cx8, cy8, w8, h8, x_e8, x_w8, y_s8;
    logic                            ok_n, ok_e, ok_s, ok_w;
    logic [2:0]                      n_cands;
    logic [1:0]                      dir;
    logic                            accept;

    mbc_map u_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (map_req),
        .o_rdata (map_q)
    );

    mbc_stack u_stack (
        .i_clk   (i_clk),
        .i_req   (stk_req),
        .o_rdata (stk_q)
    );

    assign w_eff  = mbc_pkg::eff_size(r_width);
    assign h_eff  = mbc_pkg::eff_size(r_height);
    assign accept = start && !busy;

    // neighbour coordinates with one bit of headroom
    assign cx8  = {1'b0, r_cx};
    assign cy8  = {1'b0, r_cy};
    assign w8   = {1'b0, w_eff};
    assign h8   = {1'b0, h_eff};
    assign x_e8 = cx8 + NW'(2);
    assign x_w8 = cx8 - NW'(2);
    assign y_s8 = cy8 + NW'(2);

    // strictly-inside tests; north/west written to avoid underflow
    assign ok_n = (r_cx != '0) && (cx8 < w8) && (cy8 > NW'(2)) && (cy8 < h8 + NW'(2));
    assign ok_s = (r_cx != '0) && (cx8 < w8) && (y_s8 < h8);
    assign ok_e = (r_cy != '0) && (cy8 < h8) && (x_e8 < w8);
    assign ok_w = (r_cy != '0) && (cy8 < h8) && (cx8 > NW'(2)) && (cx8 < w8 + NW'(2));

    assign n_cands = 3'(r_cand[0]) + 3'(r_cand[1]) + 3'(r_cand[2]) + 3'(r_cand[3]);
    assign dir     = mbc_pkg::pick_dir(r_cand, mbc_pkg::mod_count(r_rand, n_cands));

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_rand      = r_rand;
        n_cx        = r_cx;
        n_cy        = r_cy;
        n_ob_e      = r_ob_e;
        n_ob_w      = r_ob_w;
        n_ob_n      = r_ob_n;
        n_cand      = r_cand;
        n_nx        = r_nx;
        n_ny        = r_ny;
        n_mx        = r_mx;
        n_my        = r_my;
        n_out_valid = 1'b0;
        n_out_kind  = r_out_kind;
        n_out_x     = r_out_x;
        n_out_y     = r_out_y;
        n_out_open  = r_out_open;
        n_out_last  = r_out_last;

        map_req       = '0;
        map_req.row   = r_cy;
        stk_req       = '0;
        stk_req.addr  = r_cnt[mbc_pkg::STACK_AW-1:0];
        stk_req.wdata = {r_ny, r_nx};

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_rand = i_rand_value;
                    n_cx   = i_cell_x;
                    n_cy   = i_cell_y;
                    case (i_command)
                        mbc_pkg::CMD_START: n_state = S_CLR;
                        mbc_pkg::CMD_STEP: begin
                            if (r_cnt == '0) begin
                                // empty stack: generation done
                                n_out_valid = 1'b1;
                                n_out_kind  = mbc_pkg::KIND_DONE;
                                n_out_x     = '0;
                                n_out_y     = '0;
                                n_out_open  = 1'b0;
                                n_out_last  = 1'b1;
                            end else begin
                                n_state = S_TOP;
                            end
                        end
                        mbc_pkg::CMD_READ: n_state = S_RD0;
                        default: ;  // unknown command, no result
                    endcase
                end
            end

            S_CLR: begin
                map_req.clr   = 1'b1;
                stk_req.wr    = 1'b1;
                stk_req.addr  = '0;
                stk_req.wdata = {CW'(1), CW'(1)};
                n_cnt         = mbc_pkg::COUNT_W'(1);
                n_state       = S_ENT;
            end

            // all three rows are distinct and freshly dropped: no merge needed
            S_ENT: begin
                map_req.wr    = 1'b1;
                map_req.row   = '0;
                map_req.wdata = mbc_pkg::onehot_row(CW'(1));
                n_out_valid   = 1'b1;
                n_out_kind    = mbc_pkg::KIND_OPEN;
                n_out_x       = CW'(1);
                n_out_y       = '0;
                n_out_open    = 1'b1;
                n_out_last    = 1'b0;
                n_state       = S_EXIT;
            end

            S_EXIT: begin
                map_req.wr    = 1'b1;
                map_req.row   = h_eff - CW'(1);
                map_req.wdata = mbc_pkg::onehot_row(w_eff - CW'(2));
                n_out_valid   = 1'b1;
                n_out_kind    = mbc_pkg::KIND_OPEN;
                n_out_x       = w_eff - CW'(2);
                n_out_y       = h_eff - CW'(1);
                n_out_open    = 1'b1;
                n_out_last    = 1'b0;
                n_state       = S_FIRST;
            end

            S_FIRST: begin
                map_req.wr    = 1'b1;
                map_req.row   = CW'(1);
                map_req.wdata = mbc_pkg::onehot_row(CW'(1));
                n_out_valid   = 1'b1;
                n_out_kind    = mbc_pkg::KIND_OPEN;
                n_out_x       = CW'(1);
                n_out_y       = CW'(1);
                n_out_open    = 1'b1;
                n_out_last    = 1'b1;
                n_state       = S_IDLE;
            end

            S_TOP: begin
                stk_req.rd   = 1'b1;
                stk_req.addr = mbc_pkg::STACK_AW'(r_cnt - mbc_pkg::COUNT_W'(1));
                n_state      = S_CUR;
            end

            S_CUR: begin
                n_cx        = stk_q[CW-1:0];
                n_cy        = stk_q[2*CW-1:CW];
                map_req.rd  = 1'b1;
                map_req.row = stk_q[2*CW-1:CW];
                n_state     = S_RN;
            end

            // out-of-grid indexes wrap here; the inside tests reject them
            S_RN: begin
                n_ob_e      = map_q[x_e8[CW-1:0]];
                n_ob_w      = map_q[x_w8[CW-1:0]];
                map_req.rd  = 1'b1;
                map_req.row = r_cy - CW'(2);
                n_state     = S_RS;
            end

            S_RS: begin
                n_ob_n      = map_q[r_cx];
                map_req.rd  = 1'b1;
                map_req.row = y_s8[CW-1:0];
                n_state     = S_PICK;
            end

            S_PICK: begin
                n_cand[mbc_pkg::DIR_N] = ok_n && !r_ob_n;
                n_cand[mbc_pkg::DIR_E] = ok_e && !r_ob_e;
                n_cand[mbc_pkg::DIR_S] = ok_s && !map_q[r_cx];
                n_cand[mbc_pkg::DIR_W] = ok_w && !r_ob_w;
                n_state                = S_SEL;
            end

            S_SEL: begin
                if (n_cands == '0 || r_cnt == mbc_pkg::COUNT_W'(mbc_pkg::STACK_DEPTH)) begin
                    // dead end or full stack: pop
                    n_cnt       = r_cnt - mbc_pkg::COUNT_W'(1);
                    n_out_valid = 1'b1;
                    n_out_kind  = mbc_pkg::KIND_BACK;
                    n_out_x     = r_cx;
                    n_out_y     = r_cy;
                    n_out_open  = 1'b1;
                    n_out_last  = 1'b1;
                    n_state     = S_IDLE;
                end else begin
                    n_nx = r_cx;
                    n_ny = r_cy;
                    n_mx = r_cx;
                    n_my = r_cy;
                    case (dir)
                        mbc_pkg::DIR_N: begin
                            n_ny = r_cy - CW'(2);
                            n_my = r_cy - CW'(1);
                        end
                        mbc_pkg::DIR_E: begin
                            n_nx = r_cx + CW'(2);
                            n_mx = r_cx + CW'(1);
                        end
                        mbc_pkg::DIR_S: begin
                            n_ny = r_cy + CW'(2);
                            n_my = r_cy + CW'(1);
                        end
                        default: begin
                            n_nx = r_cx - CW'(2);
                            n_mx = r_cx - CW'(1);
                        end
                    endcase
                    n_state = S_MRD;
                end
            end

            S_MRD: begin
                map_req.rd  = 1'b1;
                map_req.row = r_my;
                n_state     = S_MWR;
            end

            S_MWR: begin
                map_req.wr    = 1'b1;
                map_req.row   = r_my;
                map_req.wdata = map_q | mbc_pkg::onehot_row(r_mx);
                stk_req.wr    = 1'b1;
                n_cnt         = r_cnt + mbc_pkg::COUNT_W'(1);
                n_out_valid   = 1'b1;
                n_out_kind    = mbc_pkg::KIND_OPEN;
                n_out_x       = r_mx;
                n_out_y       = r_my;
                n_out_open    = 1'b1;
                n_out_last    = 1'b0;
                n_state       = S_NRD;
            end

            // row may be the one just written (east/west); write has landed
            S_NRD: begin
                map_req.rd  = 1'b1;
                map_req.row = r_ny;
                n_state     = S_NWR;
            end

            S_NWR: begin
                map_req.wr    = 1'b1;
                map_req.row   = r_ny;
                map_req.wdata = map_q | mbc_pkg::onehot_row(r_nx);
                n_out_valid   = 1'b1;
                n_out_kind    = mbc_pkg::KIND_OPEN;
                n_out_x       = r_nx;
                n_out_y       = r_ny;
                n_out_open    = 1'b1;
                n_out_last    = 1'b1;
                n_state       = S_IDLE;
            end

            S_RD0: begin
                map_req.rd  = 1'b1;
                map_req.row = r_cy;
                n_state     = S_RD1;
            end

            S_RD1: begin
                n_out_valid = 1'b1;
                n_out_kind  = mbc_pkg::KIND_READ;
                n_out_x     = r_cx;
                n_out_y     = r_cy;
                n_out_open  = (r_cx < w_eff) && (r_cy < h_eff) && map_q[r_cx];
                n_out_last  = 1'b1;
                n_state     = S_IDLE;
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_width     <= CW'(21);
            r_height    <= CW'(21);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                if (i_cfg_index == mbc_pkg::REG_WIDTH) begin
                    r_width <= i_cfg_data;
                end else begin
                    r_height <= i_cfg_data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rand     <= n_rand;
        r_cx       <= n_cx;
        r_cy       <= n_cy;
        r_ob_e     <= n_ob_e;
        r_ob_w     <= n_ob_w;
        r_ob_n     <= n_ob_n;
        r_cand     <= n_cand;
        r_nx       <= n_nx;
        r_ny       <= n_ny;
        r_mx       <= n_mx;
        r_my       <= n_my;
        r_out_kind <= n_out_kind;
        r_out_x    <= n_out_x;
        r_out_y    <= n_out_y;
        r_out_open <= n_out_open;
        r_out_last <= n_out_last;
    end

    assign busy      = (r_state != S_IDLE);
    assign o_strobe  = r_out_valid;
    assign o_kind    = r_out_kind;
    assign o_pos_x   = r_out_x;
    assign o_pos_y   = r_out_y;
    assign o_is_open = r_out_open;
    assign o_last    = r_out_last;

endmodule
